[sv/fqs_pkg.sv]
// fqs_pkg: shared widths, command codes and status codes for the fifo queue with search
// depends on: nothing

package fqs_pkg;

   // fixed field widths
   localparam int DATA_W   = 32;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 5;

   // command codes carried by a request
   localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DEQUEUE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SEARCH  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_LIST    = 2'd3;

   // status codes carried by a response
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   // control from the sequencer to the match unit
   typedef struct packed {
      logic clear;
      logic step;
   } match_ctl_type;

endpackage

[sv/fqs_ifs.sv]
// fqs_ifs: request and response channel interfaces (valid/ready handshake)
// depends on: fqs_pkg

interface fqs_req_if import fqs_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         cmd;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, output cmd, output value, input ready);
   modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface fqs_rsp_if import fqs_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] data;
   logic                     found;
   logic [STATUS_W-1:0]      status;
   logic [OCC_W-1:0]         occupancy;
   logic                     last;

   modport source (output valid, output data, output found, output status,
                   output occupancy, output last, input ready);
   modport sink   (input valid, input data, input found, input status,
                   input occupancy, input last, output ready);
endinterface

[sv/fifo_queue_with_search.sv]
// fifo_queue_with_search: top level, sequencer, ring pointers and response register
// depends on: fqs_pkg, fqs_ifs, fqs_ram, fqs_match

// First-in first-out queue of signed 32-bit words held in a ring of DEPTH
// entries. Each request carries a command: enqueue, dequeue, search or list.
// Enqueue on a full queue is dropped with status full; dequeue or list on an
// empty queue gives status empty; every response reports the occupancy after
// the operation (low 5 bits). List returns one response per held entry,
// oldest first, with last set on the final one. One request is handled at a
// time and req_chan.ready is low while it runs. The single memory read port
// walks the held entries one per cycle, through one shared comparator for
// search, while the response register can take a response; a search only
// waits on it for its final entry. The response register lets the next
// request be accepted while the last response is still waiting.

module fifo_queue_with_search import fqs_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   fqs_req_if.sink    req_chan,
   fqs_rsp_if.source  rsp_chan
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_WALK = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [CMD_W-1:0]  cmd_ff, cmd_in;
   logic [DATA_W-1:0] value_ff, value_in;
   logic [IW-1:0]     head_ff, head_in;
   logic [IW-1:0]     tail_ff, tail_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [IW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     issue_left_ff, issue_left_in;
   logic [CW-1:0]     recv_left_ff, recv_left_in;
   logic              pend_ff, pend_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [OCC_W-1:0]    rsp_occ_ff, rsp_occ_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                req_fire;
   logic                slot_free;
   logic                is_search;
   logic                final_item;
   logic                consume;
   logic                advance;
   logic                rd_en;
   logic                wr_en;
   logic [DATA_W-1:0]   rd_data;
   logic                hit_now;
   match_ctl_type       match_ctl;

   logic                emit;
   logic [DATA_W-1:0]   e_data;
   logic                e_found;
   logic [STATUS_W-1:0] e_status;
   logic                e_last;

   function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] idx);
      return (idx == IW'(DEPTH - 1)) ? '0 : idx + IW'(1);
   endfunction

   // entry storage
   fqs_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (value_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_data)
   );

   // shared compare for search
   fqs_match #(
      .WIDTH (DATA_W)
   ) u_match (
      .clock   (clock),
      .reset   (reset),
      .ctl     (match_ctl),
      .data    (rd_data),
      .key     (value_ff),
      .hit_now (hit_now)
   );

   // handshake and walk pipeline control
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;
   assign is_search      = (cmd_ff == CMD_SEARCH);
   assign final_item     = (recv_left_ff == CW'(1));
   assign consume        = (state_ff == ST_WALK) && pend_ff
                           && (slot_free || (is_search && !final_item));
   assign advance        = !pend_ff || consume;
   assign rd_en          = (state_ff == ST_WALK) && advance && (issue_left_ff != '0);

   assign match_ctl.clear = (state_ff == ST_EXEC);
   assign match_ctl.step  = consume && is_search;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      value_in      = value_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      rd_ptr_in     = rd_ptr_ff;
      issue_left_in = issue_left_ff;
      recv_left_in  = recv_left_ff;
      pend_in       = pend_ff;
      wr_en         = 1'b0;
      emit          = 1'b0;
      e_data        = '0;
      e_found       = 1'b0;
      e_status      = STATUS_OK;
      e_last        = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in   = req_chan.cmd;
               value_in = req_chan.value;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (slot_free) begin
               case (cmd_ff)
                  CMD_ENQUEUE: begin
                     emit     = 1'b1;
                     state_in = ST_IDLE;
                     if (count_ff == CW'(DEPTH)) begin
                        e_status = STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        tail_in  = next_idx(tail_ff);
                        count_in = count_ff + CW'(1);
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        // empty queue: search reports not found, others report empty
                        emit     = 1'b1;
                        e_status = is_search ? STATUS_OK : STATUS_EMPTY;
                        state_in = ST_IDLE;
                     end else begin
                        rd_ptr_in     = head_ff;
                        issue_left_in = (cmd_ff == CMD_DEQUEUE) ? CW'(1) : count_ff;
                        recv_left_in  = (cmd_ff == CMD_DEQUEUE) ? CW'(1) : count_ff;
                        state_in      = ST_WALK;
                     end
                  end
               endcase
            end
         end
         ST_WALK: begin
            // issue one read per cycle while the read data slot can move
            if (rd_en) begin
               rd_ptr_in     = next_idx(rd_ptr_ff);
               issue_left_in = issue_left_ff - CW'(1);
            end
            pend_in = rd_en ? 1'b1 : (consume ? 1'b0 : pend_ff);

            if (consume) begin
               recv_left_in = recv_left_ff - CW'(1);
               case (cmd_ff)
                  CMD_DEQUEUE: begin
                     emit     = 1'b1;
                     e_data   = rd_data;
                     head_in  = next_idx(head_ff);
                     count_in = count_ff - CW'(1);
                     state_in = ST_IDLE;
                  end
                  CMD_SEARCH: begin
                     if (final_item) begin
                        emit     = 1'b1;
                        e_found  = hit_now;
                        state_in = ST_IDLE;
                     end
                  end
                  default: begin
                     emit   = 1'b1;
                     e_data = rd_data;
                     e_last = final_item;
                     if (final_item) begin
                        state_in = ST_IDLE;
                     end
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;
      rsp_occ_in    = rsp_occ_ff;
      rsp_last_in   = rsp_last_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = e_data;
         rsp_found_in  = e_found;
         rsp_status_in = e_status;
         rsp_occ_in    = OCC_W'(count_in);
         rsp_last_in   = e_last;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         issue_left_ff <= '0;
         recv_left_ff  <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         issue_left_ff <= issue_left_in;
         recv_left_ff  <= recv_left_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      value_ff      <= value_in;
      rd_ptr_ff     <= rd_ptr_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= rsp_occ_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.data      = rsp_data_ff;
   assign rsp_chan.found     = rsp_found_ff;
   assign rsp_chan.status    = rsp_status_ff;
   assign rsp_chan.occupancy = rsp_occ_ff;
   assign rsp_chan.last      = rsp_last_ff;

endmodule

[sv/fqs_ram.sv]
// fqs_ram: generic single-write, single-read memory with registered read data
// depends on: nothing

module fqs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data holds while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/fqs_match.sv]
// fqs_match: shared equality compare with a sticky hit flag, stepped once per entry
// depends on: fqs_pkg

module fqs_match import fqs_pkg::*; #(
   parameter int WIDTH = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  match_ctl_type ctl,
   input  logic [WIDTH-1:0] data,
   input  logic [WIDTH-1:0] key,
   output logic          hit_now
);

   logic hit_ff;
   logic hit_in;
   logic equal;

   // one comparator, reused for every walked entry
   assign equal   = (data == key);
   assign hit_now = hit_ff | equal;

   always_comb begin
      hit_in = hit_ff;
      if (ctl.clear) begin
         hit_in = 1'b0;
      end else if (ctl.step) begin
         hit_in = hit_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

endmodule

[sv/fqs_checker.sv]
// fqs_checker: port-level assertions for the fifo queue with search, bound to the top level
// depends on: fqs_pkg, fifo_queue_with_search

module fqs_checker import fqs_pkg::*; #(
   parameter int DEPTH = 16
) (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [DATA_W-1:0]   rsp_data,
   input logic                rsp_found,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [OCC_W-1:0]    rsp_occupancy,
   input logic                rsp_last
);

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data) && $stable(rsp_status)
         && $stable(rsp_occupancy) && $stable(rsp_last))
      else $error("stalled response changed");

   // a dropped enqueue only happens on a full queue
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_FULL) |-> rsp_occupancy == OCC_W'(DEPTH))
      else $error("full status with occupancy below depth");

   // empty status is a lone response with no data
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_EMPTY)
         |-> rsp_occupancy == '0 && rsp_data == '0 && rsp_last && !rsp_found)
      else $error("empty status with data or occupancy");

   // a search hit is a single ok response without data
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_status == STATUS_OK && rsp_data == '0 && rsp_last)
      else $error("found set outside a search response");

   // occupancy never goes past the depth
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (DEPTH < 32) |-> rsp_occupancy <= OCC_W'(DEPTH))
      else $error("occupancy beyond depth");

endmodule

bind fifo_queue_with_search fqs_checker #(
   .DEPTH (DEPTH)
) u_fqs_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_data      (rsp_chan.data),
   .rsp_found     (rsp_chan.found),
   .rsp_status    (rsp_chan.status),
   .rsp_occupancy (rsp_chan.occupancy),
   .rsp_last      (rsp_chan.last)
);

[sim/fifo_queue_with_search_tb.sv]
// fifo_queue_with_search_tb: self-checking bench for the fifo queue with search
// a directed table and then random requests; every response is checked against a queue model
// depends on: fqs_pkg, fqs_ifs, fifo_queue_with_search

`timescale 1ns / 1ps

module fifo_queue_with_search_tb;
   import fqs_pkg::*;

   localparam int DEPTH          = 16;
   localparam int RANDOM_ITEMS   = 400;
   localparam int PHASE_ITEMS    = 48;
   localparam int DRAIN_CYCLES   = DEPTH + 8;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int DIRECTED_COUNT = 26;

   typedef struct packed {
      logic signed [DATA_W-1:0] data;
      logic                     found;
      logic [STATUS_W-1:0]      status;
      logic [OCC_W-1:0]         occupancy;
      logic                     last;
   } queue_reply_type;

   typedef struct packed {
      logic [CMD_W-1:0]         cmd;
      logic signed [DATA_W-1:0] value;
      logic                     typed;
      queue_reply_type          reply;
   } stim_row_type;

   localparam queue_reply_type NO_REPLY = '0;

   logic clock;
   logic reset;

   fqs_req_if req_bus ();
   fqs_rsp_if rsp_bus ();

   fifo_queue_with_search #(.DEPTH(DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // queue model state
   logic signed [DATA_W-1:0] held_words [DEPTH];
   int unsigned              oldest_slot;
   int unsigned              free_slot;
   int unsigned              held_count;

   queue_reply_type expected_replies [$];
   int              mismatch_count;
   int              cycle_count;
   bit              calm;

   // directed requests: typed replies only where they are obvious
   stim_row_type directed_rows [DIRECTED_COUNT] = '{
      '{CMD_DEQUEUE, 32'sd0,          1'b1, '{32'sd0, 1'b0, STATUS_EMPTY, 5'd0, 1'b1}},
      '{CMD_LIST,    32'sd0,          1'b1, '{32'sd0, 1'b0, STATUS_EMPTY, 5'd0, 1'b1}},
      '{CMD_SEARCH,  32'sd0,          1'b1, '{32'sd0, 1'b0, STATUS_OK,    5'd0, 1'b1}},
      '{CMD_ENQUEUE, 32'sh7FFF_FFFF,  1'b1, '{32'sd0, 1'b0, STATUS_OK,    5'd1, 1'b1}},
      '{CMD_ENQUEUE, 32'sh8000_0000,  1'b1, '{32'sd0, 1'b0, STATUS_OK,    5'd2, 1'b1}},
      '{CMD_ENQUEUE, -32'sd1,         1'b1, '{32'sd0, 1'b0, STATUS_OK,    5'd3, 1'b1}},
      '{CMD_SEARCH,  32'sh8000_0000,  1'b0, NO_REPLY},
      '{CMD_LIST,    32'sd0,          1'b0, NO_REPLY},
      '{CMD_DEQUEUE, 32'sd0,          1'b0, NO_REPLY},
      '{CMD_ENQUEUE, 32'sd0,          1'b0, NO_REPLY},
      '{CMD_ENQUEUE, 32'sd1,          1'b0, NO_REPLY},
      '{CMD_ENQUEUE, -32'sd2,         1'b0, NO_REPLY},
      '{CMD_ENQUEUE, 32'sh5555_5555,  1'b0, NO_REPLY},
      '{CMD_ENQUEUE, 32'shAAAA_AAAA,  1'b0, NO_REPLY},
      '{CMD_ENQUEUE, 32'sh0000_FFFF,  1'b0, NO_REPLY},
      '{CMD_ENQUEUE, 32'shFFFF_0000,  1'b0, NO_REPLY},
      '{CMD_ENQUEUE, 32'sh1234_5678,  1'b0, NO_REPLY},
      '{CMD_ENQUEUE, 32'sh7FFF_FFFE,  1'b0, NO_REPLY},
      '{CMD_ENQUEUE, 32'sh8000_0001,  1'b0, NO_REPLY},
      '{CMD_ENQUEUE, 32'sh0F0F_0F0F,  1'b0, NO_REPLY},
      '{CMD_ENQUEUE, 32'shF0F0_F0F0,  1'b0, NO_REPLY},
      '{CMD_ENQUEUE, 32'sd42,         1'b0, NO_REPLY},
      '{CMD_ENQUEUE, 32'sh0000_0100,  1'b0, NO_REPLY},
      '{CMD_ENQUEUE, 32'sd9,          1'b1, '{32'sd0, 1'b0, STATUS_FULL,  5'd16, 1'b1}},
      '{CMD_LIST,    32'sd0,          1'b0, NO_REPLY},
      '{CMD_SEARCH,  32'sh0000_0100,  1'b0, NO_REPLY}
   };

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // apply one request to the queue model, optionally recording its replies
   function automatic void apply_command(input logic [CMD_W-1:0] c,
                                         input logic signed [DATA_W-1:0] v,
                                         input bit record);
      queue_reply_type r;
      int unsigned     slot;
      r = '0;
      r.last = 1'b1;
      if (c == CMD_LIST && held_count != 0) begin
         slot = oldest_slot;
         for (int i = 0; i < held_count; i++) begin
            r.data = held_words[slot];
            r.occupancy = OCC_W'(held_count);
            r.last = (i + 1 == held_count);
            if (record) expected_replies.push_back(r);
            slot = (slot + 1) % DEPTH;
         end
         return;
      end
      case (c)
         CMD_ENQUEUE: begin
            if (held_count == DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               held_words[free_slot] = v;
               free_slot = (free_slot + 1) % DEPTH;
               held_count++;
            end
         end
         CMD_DEQUEUE: begin
            if (held_count == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               r.data = held_words[oldest_slot];
               oldest_slot = (oldest_slot + 1) % DEPTH;
               held_count--;
            end
         end
         CMD_SEARCH: begin
            slot = oldest_slot;
            for (int i = 0; i < held_count; i++) begin
               if (held_words[slot] == v) r.found = 1'b1;
               slot = (slot + 1) % DEPTH;
            end
         end
         default: begin
            r.status = STATUS_EMPTY;
         end
      endcase
      r.occupancy = OCC_W'(held_count);
      if (record) expected_replies.push_back(r);
   endfunction

   // word mix: extremes, a narrow pool for repeats, and full-range values
   function automatic logic signed [DATA_W-1:0] pick_word();
      int pool_pick;
      pool_pick = int'($urandom_range(15)) - 8;
      case ($urandom_range(9))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7FFF_FFFF;
         2, 3, 4: return DATA_W'(pool_pick);
         default: return $urandom;
      endcase
   endfunction

   // present one request and wait for it to be taken
   task automatic offer_request(input logic [CMD_W-1:0] c,
                                input logic signed [DATA_W-1:0] v,
                                input bit typed,
                                input queue_reply_type reply);
      @(negedge clock);
      while (!calm && $urandom_range(99) < 24) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.cmd   = c;
      req_bus.value = v;
      do @(posedge clock); while (!req_bus.ready);
      if (typed) begin
         apply_command(c, v, 1'b0);
         expected_replies.push_back(reply);
      end else begin
         apply_command(c, v, 1'b1);
      end
   endtask

   // request side: reset, directed table, random traffic, drain
   initial begin
      logic [CMD_W-1:0]         c;
      logic signed [DATA_W-1:0] w;
      int unsigned              roll;
      bit                       filling;
      req_bus.valid = 1'b0;
      req_bus.cmd   = CMD_ENQUEUE;
      req_bus.value = '0;
      reset = 1'b1;
      calm = 1'b0;
      filling = 1'b0;
      mismatch_count = 0;
      oldest_slot = 0;
      free_slot = 0;
      held_count = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i])
         offer_request(directed_rows[i].cmd, directed_rows[i].value,
                       directed_rows[i].typed, directed_rows[i].reply);

      // alternate fill and drain phases so the queue swings between empty and full
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         calm = (n >= 160 && n < 240);
         if (n % PHASE_ITEMS == 0) filling = ~filling;
         roll = $urandom_range(99);
         if (roll < 8)       c = CMD_LIST;
         else if (roll < 26) c = CMD_SEARCH;
         else if (roll < 80) c = filling ? CMD_ENQUEUE : CMD_DEQUEUE;
         else                c = filling ? CMD_DEQUEUE : CMD_ENQUEUE;
         w = pick_word();
         // on a non-empty queue, half the searches look for a word that is held
         if (c == CMD_SEARCH && held_count != 0 && $urandom_range(1) == 1)
            w = held_words[(oldest_slot + $urandom_range(held_count - 1)) % DEPTH];
         offer_request(c, w, 1'b0, NO_REPLY);
      end
      calm = 1'b0;
      @(negedge clock);
      req_bus.valid = 1'b0;

      while (expected_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("fifo_queue_with_search_tb OK");
      end else begin
         $display("fifo_queue_with_search_tb NOT OK");
      end
      $finish;
   end

   // response side backpressure
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready = !reset && (calm || $urandom_range(99) >= 24);
      end
   end

   // compare each accepted response with the oldest expectation
   always @(posedge clock) begin
      queue_reply_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_replies.size() == 0) begin
            $error("unexpected response: data %0d status %0d", rsp_bus.data, rsp_bus.status);
            mismatch_count++;
         end else begin
            want = expected_replies.pop_front();
            if (rsp_bus.data !== want.data) begin
               $error("data: expected %0d, actual %0d", want.data, rsp_bus.data);
               mismatch_count++;
            end
            if (rsp_bus.found !== want.found) begin
               $error("found: expected %0d, actual %0d", want.found, rsp_bus.found);
               mismatch_count++;
            end
            if (rsp_bus.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_bus.status);
               mismatch_count++;
            end
            if (rsp_bus.occupancy !== want.occupancy) begin
               $error("occupancy: expected %0d, actual %0d", want.occupancy,
                      rsp_bus.occupancy);
               mismatch_count++;
            end
            if (rsp_bus.last !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, rsp_bus.last);
               mismatch_count++;
            end
         end
      end
   end

   // run limit
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("fifo_queue_with_search_tb NOT OK");
         $finish;
      end
   end

endmodule
